[rtl/core/ogrf_pkg.sv]
// Shared types and constants for the occupancy grid rectangle fill block.
package ogrf_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int CFG_W      = 9;
	localparam int COORD_W    = 16;
	localparam int REG_IDX_W  = 1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_QUERY = 2'd1,
		OP_RECT  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 1'd0,
		REG_GRID_HEIGHT = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                operation;
		logic [7:0]                fill_value;
		logic signed [COORD_W-1:0] query_x;
		logic signed [COORD_W-1:0] query_y;
		logic signed [COORD_W-1:0] corner_a_x;
		logic signed [COORD_W-1:0] corner_a_y;
		logic signed [COORD_W-1:0] corner_b_x;
		logic signed [COORD_W-1:0] corner_b_y;
	} grid_cmd_t;

	typedef struct packed {
		logic point_inside;
		logic cell_occupied;
	} grid_res_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic clip;
		logic rd_query;
		logic rd_first;
		logic fill;
		logic res_query;
		logic res_out;
		logic res_zero;
	} dp_ctl_t;

	typedef struct packed {
		logic [1:0] op;
		logic       q_inside;
		logic       rect_empty;
		logic       row_last;
	} dp_stat_t;

endpackage

[rtl/core/ogrf_dp.sv]
// Datapath: config registers, row-wide occupancy memory, clipping and row fill.
module ogrf_dp import ogrf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  grid_cmd_t            cmd,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	input  dp_ctl_t              ctl,
	output dp_stat_t             stat,
	output grid_res_t            result
);

	logic [CFG_W-1:0]     grid_width_q;
	logic [CFG_W-1:0]     grid_height_q;
	grid_cmd_t            item_q;
	logic                 fill_q;
	logic [MAX_HEIGHT-1:0] row_vld_q;
	logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0] rd_data_q;
	logic                 rd_vld_q;
	logic [MAX_WIDTH-1:0] mask_q;
	logic [COL_W-1:0]     x0_q, x1_q;
	logic [ROW_W-1:0]     y0_q, y1_q, row_q;
	grid_res_t            res_q;

	logic [CFG_W-1:0]     w_eff, h_eff;
	logic signed [16:0]   w_lim, h_lim;
	logic signed [16:0]   ax, ay, bx, by, qx, qy;
	logic signed [16:0]   lo_x, hi_x, lo_y, hi_y;
	logic signed [16:0]   cx0, cx1, cy0, cy1;
	logic [MAX_WIDTH-1:0] ones;
	logic [MAX_WIDTH-1:0] mask_d;
	logic [MAX_WIDTH-1:0] base;
	logic                 rd_en;
	logic [ROW_W-1:0]     rd_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= CFG_W'(256);
			grid_height_q <= CFG_W'(256);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_GRID_WIDTH:  grid_width_q  <= wr_data;
				REG_GRID_HEIGHT: grid_height_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign w_eff = (grid_width_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : grid_width_q;
	assign h_eff = (grid_height_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : grid_height_q;
	assign w_lim = $signed({8'b0, w_eff}) - 17'sd1;
	assign h_lim = $signed({8'b0, h_eff}) - 17'sd1;

	assign ax = $signed({item_q.corner_a_x[COORD_W-1], item_q.corner_a_x});
	assign ay = $signed({item_q.corner_a_y[COORD_W-1], item_q.corner_a_y});
	assign bx = $signed({item_q.corner_b_x[COORD_W-1], item_q.corner_b_x});
	assign by = $signed({item_q.corner_b_y[COORD_W-1], item_q.corner_b_y});
	assign qx = $signed({item_q.query_x[COORD_W-1], item_q.query_x});
	assign qy = $signed({item_q.query_y[COORD_W-1], item_q.query_y});

	always_comb begin
		lo_x = (ax < bx) ? ax : bx;
		hi_x = (ax < bx) ? bx : ax;
		lo_y = (ay < by) ? ay : by;
		hi_y = (ay < by) ? by : ay;
		cx0  = (lo_x < 17'sd0) ? 17'sd0 : lo_x;
		cy0  = (lo_y < 17'sd0) ? 17'sd0 : lo_y;
		cx1  = (hi_x > w_lim) ? w_lim : hi_x;
		cy1  = (hi_y > h_lim) ? h_lim : hi_y;
	end

	assign stat.op         = item_q.operation;
	assign stat.q_inside   = (qx >= 17'sd0) && (qx <= w_lim) && (qy >= 17'sd0) && (qy <= h_lim);
	assign stat.rect_empty = (cx0 > cx1) || (cy0 > cy1);
	assign stat.row_last   = (row_q == y1_q);

	assign ones   = '1;
	assign mask_d = (ones << x0_q) & (ones >> (COL_W'(MAX_WIDTH - 1) - x1_q));
	assign base   = rd_vld_q ? rd_data_q : {MAX_WIDTH{fill_q}};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= cmd;
		end
		if (ctl.clip) begin
			x0_q <= cx0[COL_W-1:0];
			x1_q <= cx1[COL_W-1:0];
			y0_q <= cy0[ROW_W-1:0];
			y1_q <= cy1[ROW_W-1:0];
		end
		if (ctl.rd_first) begin
			mask_q <= mask_d;
			row_q  <= y0_q;
		end else if (ctl.fill) begin
			row_q <= row_q + ROW_W'(1);
		end
	end

	// Rows not written since the last clear read as the fill value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= 1'b0;
			row_vld_q <= '0;
		end else if (ctl.clear) begin
			fill_q    <= (item_q.fill_value != 8'd0);
			row_vld_q <= '0;
		end else if (ctl.fill) begin
			row_vld_q[row_q] <= 1'b1;
		end
	end

	assign rd_en   = ctl.rd_query | ctl.rd_first | ctl.fill;
	assign rd_addr = ctl.rd_query ? item_q.query_y[ROW_W-1:0] :
	                 ctl.rd_first ? y0_q : row_q + ROW_W'(1);

	always_ff @(posedge clk) begin
		if (ctl.fill) begin
			mem[row_q] <= base | mask_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_vld_q  <= row_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.res_query) begin
			res_q.point_inside  <= 1'b1;
			res_q.cell_occupied <= base[item_q.query_x[COL_W-1:0]];
		end else if (ctl.res_out) begin
			res_q.point_inside  <= 1'b0;
			res_q.cell_occupied <= 1'b1;
		end else if (ctl.res_zero) begin
			res_q.point_inside  <= 1'b0;
			res_q.cell_occupied <= 1'b0;
		end
	end

	assign result = res_q;

endmodule

[rtl/core/ogrf_ctrl.sv]
// Controller: sequences clear, point query and row-by-row rectangle fill.
module ogrf_ctrl import ogrf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_QBIT = 5'b00100,
		ST_MASK = 5'b01000,
		ST_FILL = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (op_t'(stat.op))
					OP_CLEAR: begin
						ctl.clear    = 1'b1;
						ctl.res_zero = 1'b1;
						done_d       = 1'b1;
						state_d      = ST_IDLE;
					end
					OP_QUERY: begin
						if (stat.q_inside) begin
							ctl.rd_query = 1'b1;
							state_d      = ST_QBIT;
						end else begin
							ctl.res_out = 1'b1;
							done_d      = 1'b1;
							state_d     = ST_IDLE;
						end
					end
					OP_RECT: begin
						if (stat.rect_empty) begin
							ctl.res_zero = 1'b1;
							done_d       = 1'b1;
							state_d      = ST_IDLE;
						end else begin
							ctl.clip = 1'b1;
							state_d  = ST_MASK;
						end
					end
					default: begin
						ctl.res_zero = 1'b1;
						done_d       = 1'b1;
						state_d      = ST_IDLE;
					end
				endcase
			end
			ST_QBIT: begin
				ctl.res_query = 1'b1;
				done_d        = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_MASK: begin
				ctl.rd_first = 1'b1;
				state_d      = ST_FILL;
			end
			ST_FILL: begin
				ctl.fill = 1'b1;
				if (stat.row_last) begin
					ctl.res_zero = 1'b1;
					done_d       = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

`ifndef SYNTHESIS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == ST_EXEC)
		else $error("accepted beat did not enter execute");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe outside idle");
	a_fill_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL && stat.row_last |=> done_q && !busy)
		else $error("last row did not finish the fill");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");
`endif

endmodule

[rtl/core/occupancy_grid_rect_fill.sv]
// Top level of the occupancy grid rectangle fill block.
// Usage:
//   Command channel: drive cmd and raise start; the beat is taken at a rising
//   edge with start high and busy low. Busy stays high until the operation ends.
//   Result channel: done pulses for one cycle with result valid; the receiver
//   cannot stall it, so it must take the beat in that cycle.
//   Config: wr_en/wr_index/wr_data write grid_width (0) or grid_height (1);
//   write only while busy is low and no result is pending.
// Operation: a rectangle is filled by a read-modify-write of the row-wide grid
//   memory, one row per cycle; a query outside the grid and a rectangle clipped
//   away finish without touching the memory.
//   A new command may be accepted in the same cycle that done is high.
// Reset: grid all free, grid_width = grid_height = 256, idle at once; per-row
//   valid flags let clear and reset take effect without sweeping the memory.
module occupancy_grid_rect_fill import ogrf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  grid_cmd_t            cmd,
	output logic                 done,
	output grid_res_t            result,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	ogrf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.ctl    (ctl)
	);

	ogrf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.ctl      (ctl),
		.stat     (stat),
		.result   (result)
	);

endmodule

[verif/grid_result_check.sv]
`timescale 1ns / 100ps
// Result checker for the occupancy grid: keeps its own grid copy and compares every result beat.
module grid_result_check import ogrf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  grid_cmd_t            cmd,
	input  logic                 done,
	input  grid_res_t            result,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output int                   errors,
	output int                   pending,
	output int                   checked
);

	logic [MAX_WIDTH-1:0] occupancy [MAX_HEIGHT];
	logic [CFG_W-1:0]     width_reg;
	logic [CFG_W-1:0]     height_reg;
	grid_res_t            expected_results[$];

	function automatic grid_res_t apply_command(grid_cmd_t c);
		grid_res_t            r;
		int                   w, h, x, y, x0, x1, y0, y1;
		logic [MAX_WIDTH-1:0] row_mask;
		r = '0;
		w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
		h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
		case (op_t'(c.operation))
		OP_CLEAR: begin
			for (y = 0; y < MAX_HEIGHT; y++)
				occupancy[y] = (c.fill_value != 8'd0) ? '1 : '0;
		end
		OP_QUERY: begin
			x = int'(c.query_x);
			y = int'(c.query_y);
			if (x >= 0 && x < w && y >= 0 && y < h) begin
				r.point_inside  = 1'b1;
				r.cell_occupied = occupancy[y][x];
			end else begin
				r.cell_occupied = 1'b1;
			end
		end
		OP_RECT: begin
			x0 = int'(c.corner_a_x);
			x1 = int'(c.corner_b_x);
			if (x1 < x0) begin
				x  = x0;
				x0 = x1;
				x1 = x;
			end
			y0 = int'(c.corner_a_y);
			y1 = int'(c.corner_b_y);
			if (y1 < y0) begin
				y  = y0;
				y0 = y1;
				y1 = y;
			end
			if (x0 < 0) x0 = 0;
			if (y0 < 0) y0 = 0;
			if (x1 > w - 1) x1 = w - 1;
			if (y1 > h - 1) y1 = h - 1;
			if (x0 <= x1 && y0 <= y1) begin
				row_mask = '0;
				for (x = x0; x <= x1; x++)
					row_mask[x] = 1'b1;
				for (y = y0; y <= y1; y++)
					occupancy[y] = occupancy[y] | row_mask;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grid_res_t want;
		if (!arst_n) begin
			for (int y = 0; y < MAX_HEIGHT; y++)
				occupancy[y] = '0;
			width_reg  = CFG_W'(MAX_WIDTH);
			height_reg = CFG_W'(MAX_HEIGHT);
			expected_results.delete();
			errors   = 0;
			pending  = 0;
			checked  = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with no command outstanding: inside %0b occupied %0b",
						$time, result.point_inside, result.cell_occupied);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (result.point_inside !== want.point_inside) begin
						$display("%0t: result %0d point_inside: expected %0b, actual %0b",
							$time, checked, want.point_inside, result.point_inside);
						errors++;
					end
					if (result.cell_occupied !== want.cell_occupied) begin
						$display("%0t: result %0d cell_occupied: expected %0b, actual %0b",
							$time, checked, want.cell_occupied, result.cell_occupied);
						errors++;
					end
					checked++;
				end
			end
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
				REG_GRID_WIDTH:  width_reg = wr_data;
				REG_GRID_HEIGHT: height_reg = wr_data;
				default: ;
				endcase
			end
			if (start && !busy) begin
				expected_results.push_back(apply_command(cmd));
			end
			pending = expected_results.size();
		end
	end

endmodule

[verif/tb_occupancy_grid_rect_fill.sv]
`timescale 1ns / 100ps
// Testbench top: drives grid commands and size writes into the occupancy grid and gives the verdict.
module tb_occupancy_grid_rect_fill;
	import ogrf_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 300;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 50;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 start    = 1'b0;
	grid_cmd_t            cmd      = '0;
	logic                 wr_en    = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0]     wr_data  = '0;
	logic                 busy;
	logic                 done;
	grid_res_t            result;
	int                   errors, pending, checked;
	int                   stall_cycles = 0;
	int                   cur_w = MAX_WIDTH;
	int                   cur_h = MAX_HEIGHT;
	int                   n_clear = 0, n_query = 0, n_rect = 0, n_none = 0, n_sizes = 1;

	occupancy_grid_rect_fill uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	grid_result_check result_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && !(start && !busy) && !done && !wr_en)
			stall_cycles <= stall_cycles + 1;
		else
			stall_cycles <= 0;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic grid_cmd_t noise_command();
		grid_cmd_t c;
		c.operation  = 2'($urandom);
		c.fill_value = 8'($urandom);
		c.query_x    = 16'($urandom);
		c.query_y    = 16'($urandom);
		c.corner_a_x = 16'($urandom);
		c.corner_a_y = 16'($urandom);
		c.corner_b_x = 16'($urandom);
		c.corner_b_y = 16'($urandom);
		return c;
	endfunction

	function automatic grid_cmd_t query_cmd(int x, int y);
		grid_cmd_t c;
		c           = noise_command();
		c.operation = OP_QUERY;
		c.query_x   = 16'(x);
		c.query_y   = 16'(y);
		return c;
	endfunction

	function automatic grid_cmd_t rect_cmd(int ax, int ay, int bx, int by);
		grid_cmd_t c;
		c            = noise_command();
		c.operation  = OP_RECT;
		c.corner_a_x = 16'(ax);
		c.corner_a_y = 16'(ay);
		c.corner_b_x = 16'(bx);
		c.corner_b_y = 16'(by);
		return c;
	endfunction

	function automatic grid_cmd_t clear_cmd(logic [7:0] fill);
		grid_cmd_t c;
		c            = noise_command();
		c.operation  = OP_CLEAR;
		c.fill_value = fill;
		return c;
	endfunction

	// mostly within the grid or just past its edges, sometimes anywhere in the 16-bit range
	function automatic int pick_coord(int span);
		if ($urandom_range(0, 99) < 12)
			return int'($signed(16'($urandom)));
		return int'($urandom_range(0, span + 4)) - 2;
	endfunction

	function automatic grid_cmd_t random_command(int span_x, int span_y);
		grid_cmd_t c;
		int        pick, ax, ay, bx, by;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			c = clear_cmd(($urandom_range(0, 99) < 60) ? 8'd0 : 8'($urandom));
		end else if (pick < 7) begin
			c           = noise_command();
			c.operation = OP_NONE;
		end else if (pick < 50) begin
			c = query_cmd(pick_coord(span_x), pick_coord(span_y));
		end else begin
			ax = pick_coord(span_x);
			ay = pick_coord(span_y);
			if ($urandom_range(0, 99) < 80) begin
				bx = ax + int'($urandom_range(0, 16)) - 8;
				by = ay + int'($urandom_range(0, 16)) - 8;
			end else begin
				bx = pick_coord(span_x);
				by = pick_coord(span_y);
			end
			c = rect_cmd(ax, ay, bx, by);
		end
		return c;
	endfunction

	task automatic send_command(input grid_cmd_t c);
		@(negedge clk);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		case (op_t'(c.operation))
		OP_CLEAR: n_clear++;
		OP_QUERY: n_query++;
		OP_RECT:  n_rect++;
		default:  n_none++;
		endcase
	endtask

	task automatic pause(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain();
		pause(1);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int value);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= CFG_W'(value);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_grid(input int w, input int h);
		drain();
		write_reg(REG_GRID_WIDTH, w);
		write_reg(REG_GRID_HEIGHT, h);
		cur_w = w;
		cur_h = h;
		n_sizes++;
	endtask

	task automatic run_phase(input int items, input bit with_gaps);
		int span_x, span_y;
		span_x = (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
		span_y = (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
		for (int i = 0; i < items; i++) begin
			send_command(random_command(span_x, span_y));
			if (with_gaps && $urandom_range(0, 99) < 12)
				pause($urandom_range(1, 15));
		end
	endtask

	initial begin
		int phase_w[PHASES] = '{256, 1, 0, 12, 511, 2, 256, 17, 300, 0};
		int phase_h[PHASES] = '{256, 1, 9, 0, 300, 256, 2, 33, 511, 0};
		grid_cmd_t idle_op;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_command(query_cmd(0, 0));
		send_command(query_cmd(255, 255));
		send_command(query_cmd(256, 0));
		send_command(query_cmd(-1, 5));
		send_command(query_cmd(32767, -32768));
		send_command(rect_cmd(10, 20, 3, 5));
		send_command(query_cmd(3, 5));
		send_command(query_cmd(10, 20));
		send_command(query_cmd(2, 5));
		send_command(query_cmd(11, 20));
		send_command(rect_cmd(-5, -5, -1, -1));
		send_command(rect_cmd(300, 0, 400, 10));
		send_command(query_cmd(255, 0));
		send_command(rect_cmd(-32768, -32768, 32767, 2));
		send_command(query_cmd(255, 2));
		send_command(query_cmd(0, 3));
		idle_op           = noise_command();
		idle_op.operation = OP_NONE;
		send_command(idle_op);
		send_command(clear_cmd(8'h80));
		send_command(query_cmd(200, 200));
		send_command(clear_cmd(8'h00));
		send_command(query_cmd(-32768, 32767));

		// empty grid: queries miss, rectangles leave the store alone
		set_grid(0, 5);
		send_command(query_cmd(0, 0));
		send_command(rect_cmd(0, 0, 10, 10));
		// clear reaches beyond a small grid and survives the resize
		set_grid(4, 4);
		send_command(clear_cmd(8'h01));
		set_grid(256, 256);
		send_command(query_cmd(100, 100));
		send_command(clear_cmd(8'h00));

		phase_w[PHASES - 1] = $urandom_range(1, 511);
		phase_h[PHASES - 1] = $urandom_range(1, 511);
		for (int p = 0; p < PHASES; p++) begin
			set_grid(phase_w[p], phase_h[p]);
			run_phase(PHASE_ITEMS, p != PHASES - 1);
		end

		pause(1);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d commands: %0d queries, %0d rectangles, %0d clears, %0d unused op",
			n_clear + n_query + n_rect + n_none, n_query, n_rect, n_clear, n_none);
		$display("Checked %0d results over %0d grid sizes, empty and oversized grids included",
			checked, n_sizes);
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
